// ===== hw/rtl/ccic_pkg.sv =====
// ----------------------------------------------------------------------------
// ccic_pkg
// Shared types and constants of the complex CIC decimator.
// ----------------------------------------------------------------------------
package ccic_pkg;

  localparam int unsigned NumIntegrators = 4;
  localparam int unsigned NumCombs       = 4;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned PhaseW         = 16;

  localparam logic [PhaseW-1:0] DecimationReset = PhaseW'(8);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef logic [SampleW-1:0] word_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [SampleW-1:0] sample_re;
    logic signed [SampleW-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_re;
    logic signed [SampleW-1:0] out_im;
  } out_item_t;

endpackage

// ===== hw/rtl/complex_cic_decimator_core.sv =====
// ----------------------------------------------------------------------------
// complex_cic_decimator_core
// CIC decimator for complex Q1.15 samples with 16-bit wraparound arithmetic.
// One item is accepted per cycle whenever the output register is free or being
// drained; a sample finishes in the cycle it is accepted and its result, if
// any, is visible the next cycle. The integrator and comb cascades form one
// 16-bit add/subtract chain between the input handshake and the result
// register, which sets the clock rate. A result is produced for the first
// sample after reset or clear and then once every "decimation" samples (zero
// acts as one). A clear item zeroes integrators, comb delays and phase and
// produces no result. Write decimation only while the block is idle.
// ----------------------------------------------------------------------------
module complex_cic_decimator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ccic_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ccic_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  ccic_pkg::word_t integ_re_q [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t integ_im_q [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t integ_re_d [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t integ_im_d [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t delay_re_q [ccic_pkg::NumCombs];
  ccic_pkg::word_t delay_im_q [ccic_pkg::NumCombs];
  ccic_pkg::word_t delay_re_d [ccic_pkg::NumCombs];
  ccic_pkg::word_t delay_im_d [ccic_pkg::NumCombs];

  logic [ccic_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [ccic_pkg::PhaseW-1:0] decim_q;
  logic [ccic_pkg::PhaseW-1:0] ratio;
  logic [ccic_pkg::PhaseW:0]   phase_inc;

  logic                in_fire, is_clear, is_sample, emit;
  logic                out_valid_q, out_valid_d;
  ccic_pkg::out_item_t out_item_q, out_item_d;
  ccic_pkg::word_t     comb_re, comb_im;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_clear    = in_item_i.kind == ccic_pkg::KIND_CLEAR;
  assign is_sample   = in_fire && !is_clear;
  assign emit        = is_sample && (phase_q == '0);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign ratio     = (decim_q == '0) ? ccic_pkg::PhaseW'(1) : decim_q;
  assign phase_inc = {1'b0, phase_q} + (ccic_pkg::PhaseW+1)'(1);

  always_comb begin
    ccic_pkg::word_t acc_re, acc_im;
    acc_re = ccic_pkg::word_t'(in_item_i.sample_re);
    acc_im = ccic_pkg::word_t'(in_item_i.sample_im);
    for (int i = 0; i < ccic_pkg::NumIntegrators; i++) begin
      acc_re        = acc_re + integ_re_q[i];
      acc_im        = acc_im + integ_im_q[i];
      integ_re_d[i] = acc_re;
      integ_im_d[i] = acc_im;
    end
    for (int i = 0; i < ccic_pkg::NumCombs; i++) begin
      delay_re_d[i] = acc_re;
      delay_im_d[i] = acc_im;
      acc_re        = acc_re - delay_re_q[i];
      acc_im        = acc_im - delay_im_q[i];
    end
    comb_re = acc_re;
    comb_im = acc_im;
  end

  always_comb begin
    phase_d = (phase_inc >= {1'b0, ratio}) ? '0 : phase_inc[ccic_pkg::PhaseW-1:0];
    out_item_d.out_re = signed'(comb_re);
    out_item_d.out_im = signed'(comb_im);
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ccic_pkg::NumIntegrators; i++) begin
        integ_re_q[i] <= '0;
        integ_im_q[i] <= '0;
      end
      for (int i = 0; i < ccic_pkg::NumCombs; i++) begin
        delay_re_q[i] <= '0;
        delay_im_q[i] <= '0;
      end
      phase_q     <= '0;
      decim_q     <= ccic_pkg::DecimationReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        decim_q <= cfg_data_i;
      end
      if (in_fire && is_clear) begin
        for (int i = 0; i < ccic_pkg::NumIntegrators; i++) begin
          integ_re_q[i] <= '0;
          integ_im_q[i] <= '0;
        end
        for (int i = 0; i < ccic_pkg::NumCombs; i++) begin
          delay_re_q[i] <= '0;
          delay_im_q[i] <= '0;
        end
        phase_q <= '0;
      end else if (is_sample) begin
        integ_re_q <= integ_re_d;
        integ_im_q <= integ_im_d;
        phase_q    <= phase_d;
        if (emit) begin
          delay_re_q <= delay_re_d;
          delay_im_q <= delay_im_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= out_item_d;
    end
  end

  a_clear_zeroes_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_clear |=> phase_q == '0 && integ_re_q[0] == '0 && delay_im_q[0] == '0)
    else $error("clear item left filter state");

  a_emit_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("phase zero sample produced no result");

  a_quiet_sample_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_sample && phase_q != '0 && out_valid_o && !out_ready_i
    |=> out_valid_o && $stable(out_item_o))
    else $error("sample off phase zero disturbed the result");

  a_no_load_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while result register is blocked");

endmodule

// ===== sim/ccic_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccic_checker
// Watches the sample, result and decimation channels of the complex CIC
// decimator. Keeps its own integrator, comb and phase state, computes the
// result that each accepted sample is due to produce, and compares every
// accepted result field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module ccic_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ccic_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ccic_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [15:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  ccic_pkg::word_t             acc_re   [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t             acc_im   [ccic_pkg::NumIntegrators];
  ccic_pkg::word_t             dly_re   [ccic_pkg::NumCombs];
  ccic_pkg::word_t             dly_im   [ccic_pkg::NumCombs];
  logic [ccic_pkg::PhaseW-1:0] phase;
  logic [ccic_pkg::PhaseW-1:0] decim;
  ccic_pkg::out_item_t         due_results[$];
  int                          errs;

  function automatic void wipe_filter();
    for (int i = 0; i < ccic_pkg::NumIntegrators; i++) begin
      acc_re[i] = '0;
      acc_im[i] = '0;
    end
    for (int i = 0; i < ccic_pkg::NumCombs; i++) begin
      dly_re[i] = '0;
      dly_im[i] = '0;
    end
    phase = '0;
  endfunction

  function automatic logic cic_advance(input ccic_pkg::in_item_t it,
                                       output ccic_pkg::out_item_t res);
    ccic_pkg::word_t re;
    ccic_pkg::word_t im;
    ccic_pkg::word_t prev_re;
    ccic_pkg::word_t prev_im;
    logic [16:0]     ratio;
    logic [16:0]     nxt;
    logic            fire;
    re = it.sample_re;
    im = it.sample_im;
    for (int i = 0; i < ccic_pkg::NumIntegrators; i++) begin
      re = re + acc_re[i];
      im = im + acc_im[i];
      acc_re[i] = re;
      acc_im[i] = im;
    end
    ratio = (decim == '0) ? 17'd1 : {1'b0, decim};
    fire  = (phase == '0);
    nxt   = {1'b0, phase} + 17'd1;
    phase = (nxt >= ratio) ? '0 : nxt[ccic_pkg::PhaseW-1:0];
    res = '0;
    if (fire) begin
      for (int i = 0; i < ccic_pkg::NumCombs; i++) begin
        prev_re = re;
        prev_im = im;
        re = re - dly_re[i];
        im = im - dly_im[i];
        dly_re[i] = prev_re;
        dly_im[i] = prev_im;
      end
      res.out_re = re;
      res.out_im = im;
    end
    return fire;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ccic_pkg::out_item_t res;
    ccic_pkg::out_item_t want;
    if (!rst_ni) begin
      decim = ccic_pkg::DecimationReset;
      wipe_filter();
      due_results.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got re %0d im %0d",
                   $time, out_item_i.out_re, out_item_i.out_im);
          errs++;
        end else begin
          want = due_results.pop_front();
          if (out_item_i.out_re !== want.out_re) begin
            $display("%0t: out_re mismatch: expected %0d, got %0d",
                     $time, want.out_re, out_item_i.out_re);
            errs++;
          end
          if (out_item_i.out_im !== want.out_im) begin
            $display("%0t: out_im mismatch: expected %0d, got %0d",
                     $time, want.out_im, out_item_i.out_im);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.kind == ccic_pkg::KIND_CLEAR) begin
          wipe_filter();
        end else if (cic_advance(in_item_i, res)) begin
          due_results.push_back(res);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        decim = cfg_data_i;
      end
      fail_count_o <= errs;
      pending_o    <= due_results.size();
    end
  end

endmodule

// ===== sim/tb_complex_cic_decimator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_cic_decimator_core
// Drives the complex CIC decimator with a directed run over field extremes,
// clears, zero and lowered decimation, then random phases at several ratios
// with bursty input, a stalling receiver and one long output hold-off.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_complex_cic_decimator_core;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseItems = 50;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ccic_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ccic_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data = '0;
  int                  fail_count;
  int                  pending;

  int          burst_left = 0;
  bit          steady = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_tick = 0;
  int          rx_mode = 0;
  int          idle_cycles = 0;

  complex_cic_decimator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  ccic_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic feed_item(input ccic_pkg::kind_e kind, input logic signed [15:0] re,
                           input logic signed [15:0] im);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid          <= 1'b1;
    in_item.kind      <= kind;
    in_item.sample_re <= re;
    in_item.sample_im <= im;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_decimation(input logic [15:0] ratio);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ratio;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver: switches among three stall patterns, honors long hold requests
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_decim[9];
    phase_decim = '{1, 4, 2, 7, 16, 65535, 3, 1, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ratio of eight: wrap the phase once, then clear mid-count
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh7fff, 16'sh7fff);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh8000, 16'sh8000);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh7fff, 16'sh8000);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh8000, 16'sh7fff);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0000, 16'sh0000);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0001, -16'sh0001);
    feed_item(ccic_pkg::KIND_SAMPLE, -16'sh0001, 16'sh0001);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh5555, 16'shaaaa);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'shaaaa, 16'sh5555);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh1234, 16'sh4321);
    feed_item(ccic_pkg::KIND_CLEAR, 16'sh7fff, 16'sh8000);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0100, 16'shff00);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0200, 16'shfe00);

    set_decimation(16'd1);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh7fff, 16'sh7fff);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh8000, 16'sh8000);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh8000, 16'sh7fff);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh7fff, 16'sh8000);

    set_decimation(16'd0);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0003, 16'shfffd);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh7000, 16'sh9000);

    // ratio lowered to equal the running phase
    set_decimation(16'd3);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0010, 16'sh0020);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0030, 16'sh0040);
    set_decimation(16'd2);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0050, 16'sh0060);
    feed_item(ccic_pkg::KIND_SAMPLE, 16'sh0070, 16'sh0080);

    for (int p = 0; p < 9; p++) begin
      set_decimation(phase_decim[p] == 0 ? 16'($urandom_range(1, 12))
                                          : 16'(phase_decim[p]));
      steady = (p == 0) || ($urandom_range(0, 3) == 0);
      if (p == 0) hold_req <= hold_req + 1;
      for (int n = 0; n < PhaseItems; n++) begin
        feed_item(($urandom_range(0, 19) == 0) ? ccic_pkg::KIND_CLEAR
                                               : ccic_pkg::KIND_SAMPLE,
                  pick_sample(), pick_sample());
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== complex_cic_decimator_core.f =====
hw/rtl/ccic_pkg.sv
hw/rtl/complex_cic_decimator_core.sv
sim/ccic_checker.sv
sim/tb_complex_cic_decimator_core.sv
